// ===== hw/rtl/hpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_pkg
// Types, constants and helpers shared by the histogram percentile collector.
// ----------------------------------------------------------------------------
package hpc_pkg;

   localparam int NUM_BINS = 32;
   localparam int BIN_AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int BIN_CW   = $clog2(NUM_BINS + 1);
   localparam int CUM_W    = 32 + BIN_CW;
   localparam int INDEX_W  = 5;
   localparam int CSR_IW   = 3;
   localparam int PROD_W   = 56;

   typedef enum logic [CSR_IW-1:0] {
      REG_MIN_VALUE   = 3'd0,
      REG_BIN_LENGTH  = 3'd1,
      REG_NUM_BINS    = 3'd2,
      REG_OUTPUT_MODE = 3'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_COUNT  = 2'd0,
      MODE_PROB   = 2'd1,
      MODE_CUM    = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BIN  = 2'd0,
      KIND_PCT  = 2'd1,
      KIND_STAT = 2'd2
   } kind_type;

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_REPORT = 1'b1
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ADD, ST_SDIV, ST_SRD, ST_SWR,
      ST_RSTART, ST_RRD, ST_RDAT, ST_RDIV, ST_PCT,
      ST_PDIV, ST_PMUL, ST_PNEXT, ST_RNEXT, ST_STAT, ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   localparam logic [2:0] LAST_PCT = 3'd4;

   function automatic logic [6:0] pct_num(input logic [2:0] p);
      logic [6:0] r;
      case (p)
         3'd0:    r = 7'd5;
         3'd1:    r = 7'd25;
         3'd2:    r = 7'd50;
         3'd3:    r = 7'd75;
         3'd4:    r = 7'd95;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat_x(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647)        r = 32'sh7FFFFFFF;
      else if (x < -64'sd2147483648)  r = 32'sh80000000;
      else                            r = x[31:0];
      return r;
   endfunction

   function automatic logic [31:0] sat_y(input logic [63:0] y);
      return (y[63:32] != 32'd0) ? 32'hFFFFFFFF : y[31:0];
   endfunction

endpackage

// ===== hw/rtl/hpc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_if
// Valid/ready channels of the collector: request, response and register write.
// ----------------------------------------------------------------------------
interface hpc_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [31:0] sample_value;
   modport source (output valid, action, sample_value, input ready);
   modport sink   (input valid, action, sample_value, output ready);
endinterface

interface hpc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [4:0]         index;
   logic signed [31:0] x_value;
   logic [31:0]        y_value;
   logic [31:0]        sample_count;
   logic signed [63:0] sample_sum;
   logic signed [31:0] sample_min;
   logic signed [31:0] sample_max;
   logic [63:0]        square_sum;
   logic               last;
   modport source (output valid, kind, index, x_value, y_value, sample_count,
                   sample_sum, sample_min, sample_max, square_sum, last,
                   input ready);
   modport sink   (input valid, kind, index, x_value, y_value, sample_count,
                   sample_sum, sample_min, sample_max, square_sum, last,
                   output ready);
endinterface

interface hpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpc_div (
   input  logic                clock,
   input  logic                reset,
   input  hpc_pkg::div_req_type req,
   output hpc_pkg::div_rsp_type rsp
);
   import hpc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  step_ff, step_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] div_ff, div_in;
   logic [64:0] rem_ff, rem_in;
   logic [64:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff[63:0], quo_ff[63]};
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = 6'd0;
         quo_in  = req.dividend;
         div_in  = req.divisor;
         rem_in  = 65'd0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = shifted - {1'b0, div_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/hpc_bin_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_bin_ram
// Bin count store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hpc_bin_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [hpc_pkg::BIN_AW-1:0] wr_addr,
   input  logic [31:0]                wr_data,
   input  logic [hpc_pkg::BIN_AW-1:0] rd_addr,
   output logic [31:0]                rd_data
);
   import hpc_pkg::*;

   logic [31:0] mem [NUM_BINS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/histogram_percentile_collector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_percentile_collector_top
// Bins Q16.16 samples, keeps running statistics and streams reports.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  req_chan  in   action, sample_value
//  rsp_chan  out  kind, index, x_value, y_value, statistics, last
//  csr_chan  in   register index, write data
//
//  A sample passes ST_ADD, ST_SRD and ST_SWR, plus ST_SDIV on the shared
//  divider when it falls inside the bins. A report reads each bin, divides
//  it outside count mode, and in cumulative mode tests each percentile,
//  dividing again on a crossing; each item waits in ST_OUT for its handshake.
//  Reset clears the statistics, registers and bin valid bits at once.
//  A response stall holds the sequencer; no request is taken during a report.
module histogram_percentile_collector_top (
   input logic      clock,
   input logic      reset,
   hpc_req_if.sink  req_chan,
   hpc_rsp_if.source rsp_chan,
   hpc_csr_if.sink  csr_chan
);
   import hpc_pkg::*;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic signed [31:0] min_value_ff;
   logic [30:0]        bin_length_ff;
   logic [5:0]         num_bins_ff;
   mode_type           mode_ff;

   logic [31:0]        total_ff, total_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [31:0] min_ff, min_in, max_ff, max_in;
   logic [63:0]        sqsum_ff, sqsum_in;

   logic signed [31:0] sv_ff, sv_in;
   logic [63:0]        sq_ff, sq_in;
   logic [BIN_AW-1:0]  bin_ff, bin_in, i_ff, i_in;
   logic [2:0]         p_ff, p_in;
   logic [CUM_W-1:0]   c_ff, c_in, c0_ff, c0_in;
   logic signed [63:0] x0_ff, x0_in, centre_ff, centre_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [NUM_BINS-1:0] valid_ff, valid_in;
   logic               rd_valid_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff, kind_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic signed [31:0] x_ff, x_in;
   logic [31:0]        y_ff, y_in;
   logic [31:0]        o_count_ff, o_count_in;
   logic signed [63:0] o_sum_ff, o_sum_in;
   logic signed [31:0] o_min_ff, o_min_in, o_max_ff, o_max_in;
   logic [63:0]        o_sq_ff, o_sq_in;
   logic               last_ff, last_in;

   div_req_type        dreq;
   div_rsp_type        drsp;

   logic               wr_en;
   logic [31:0]        wr_data, rd_data, cnt;
   logic [BIN_AW-1:0]  rd_addr;

   logic [30:0]        len;
   logic [BIN_CW-1:0]  nb;
   logic signed [63:0] sv64, lo64, top64, diff64, sq_s, sum_new, x_pct;
   logic [63:0]        nblen, tgt, a0, a1;
   logic [64:0]        sq_add;
   logic [CUM_W-1:0]   c_new;

   assign len     = (bin_length_ff == 31'd0) ? 31'd1 : bin_length_ff;
   assign nb      = (num_bins_ff == 6'd0) ? BIN_CW'(1) :
                    (num_bins_ff > 6'(NUM_BINS)) ? BIN_CW'(NUM_BINS) :
                    BIN_CW'(num_bins_ff);
   assign cnt     = rd_valid_ff ? rd_data : 32'd0;
   assign rd_addr = (state_ff == ST_SRD) ? bin_ff : i_ff;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sqsum_in     = sqsum_ff;
      sv_in        = sv_ff;
      sq_in        = sq_ff;
      bin_in       = bin_ff;
      i_in         = i_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      c0_in        = c0_ff;
      x0_in        = x0_ff;
      centre_in    = centre_ff;
      prod_in      = prod_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      index_in     = index_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      o_count_in   = o_count_ff;
      o_sum_in     = o_sum_ff;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      o_sq_in      = o_sq_ff;
      last_in      = last_ff;
      dreq         = '0;
      wr_en        = 1'b0;
      wr_data      = (cnt == 32'hFFFFFFFF) ? cnt : cnt + 32'd1;

      sv64    = 64'(sv_ff);
      lo64    = 64'(min_value_ff);
      nblen   = 64'(nb) * 64'(len);
      top64   = lo64 + $signed(nblen);
      diff64  = sv64 - lo64;
      sq_s    = sv64 * sv64;
      sum_new = sum_ff + sv64;
      sq_add  = {1'b0, sqsum_ff} + {1'b0, sq_ff};
      c_new   = c_ff + CUM_W'(cnt);
      tgt     = 64'(pct_num(p_ff)) * 64'(total_ff);
      a0      = 64'(c0_ff) * 64'd100;
      a1      = 64'(c_ff) * 64'd100;
      x_pct   = x0_ff + $signed({32'd0, prod_ff[PROD_W-1:24]});

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sv_in    = req_chan.sample_value;
               state_in = (req_chan.action == ACT_REPORT) ? ST_RSTART : ST_ADD;
            end
         end
         ST_ADD: begin
            sq_in = sq_s;
            if (total_ff != 32'hFFFFFFFF) total_in = total_ff + 32'd1;
            if ((sum_ff[63] == sv_ff[31]) && (sum_new[63] != sv_ff[31]))
               sum_in = sv_ff[31] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
               sum_in = sum_new;
            if (sv_ff < min_ff) min_in = sv_ff;
            if (sv_ff > max_ff) max_in = sv_ff;
            if (sv64 < lo64) begin
               bin_in   = '0;
               state_in = ST_SRD;
            end else if (sv64 < top64) begin
               dreq.start    = 1'b1;
               dreq.dividend = diff64;
               dreq.divisor  = 64'(len);
               state_in      = ST_SDIV;
            end else begin
               bin_in   = BIN_AW'(nb - BIN_CW'(1));
               state_in = ST_SRD;
            end
         end
         ST_SDIV: begin
            if (drsp.done) begin
               if (drsp.quotient >= 64'(nb)) bin_in = BIN_AW'(nb - BIN_CW'(1));
               else                          bin_in = BIN_AW'(drsp.quotient);
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            sqsum_in = sq_add[64] ? 64'hFFFFFFFFFFFFFFFF : sq_add[63:0];
            state_in = ST_SWR;
         end
         ST_SWR: begin
            wr_en            = 1'b1;
            valid_in[bin_ff] = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_RSTART: begin
            i_in      = '0;
            c_in      = '0;
            c0_in     = '0;
            x0_in     = lo64;
            centre_in = lo64 + 64'(len >> 1);
            if (mode_ff == MODE_COUNT ||
                ((mode_ff inside {MODE_PROB, MODE_CUM}) && total_ff != 32'd0))
               state_in = ST_RRD;
            else
               state_in = ST_STAT;
         end
         ST_RRD: state_in = ST_RDAT;
         ST_RDAT: begin
            if (mode_ff == MODE_COUNT) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_BIN;
               index_in     = INDEX_W'(i_ff);
               x_in         = sat_x(centre_ff);
               y_in         = cnt;
               o_count_in   = '0;
               o_sum_in     = '0;
               o_min_in     = '0;
               o_max_in     = '0;
               o_sq_in      = '0;
               last_in      = 1'b0;
               ret_in       = ST_RNEXT;
               state_in     = ST_OUT;
            end else begin
               dreq.start   = 1'b1;
               dreq.divisor = 64'(total_ff);
               if (mode_ff == MODE_CUM) begin
                  c_in          = c_new;
                  dreq.dividend = 64'(c_new) << 16;
               end else begin
                  dreq.dividend = 64'(cnt) << 16;
               end
               state_in = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (drsp.done) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_BIN;
               index_in     = INDEX_W'(i_ff);
               x_in         = sat_x(centre_ff);
               y_in         = sat_y(drsp.quotient);
               o_count_in   = '0;
               o_sum_in     = '0;
               o_min_in     = '0;
               o_max_in     = '0;
               o_sq_in      = '0;
               last_in      = 1'b0;
               p_in         = 3'd0;
               ret_in       = (mode_ff == MODE_CUM) ? ST_PCT : ST_RNEXT;
               state_in     = ST_OUT;
            end
         end
         ST_PCT: begin
            if (a0 < tgt && a1 >= tgt) begin
               dreq.start    = 1'b1;
               dreq.dividend = (tgt - a0) << 24;
               dreq.divisor  = a1 - a0;
               state_in      = ST_PDIV;
            end else begin
               state_in = ST_PNEXT;
            end
         end
         ST_PDIV: begin
            if (drsp.done) begin
               prod_in  = PROD_W'(len) * PROD_W'(drsp.quotient[24:0]);
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_PCT;
            index_in     = INDEX_W'(p_ff);
            x_in         = sat_x(x_pct);
            y_in         = '0;
            o_count_in   = '0;
            o_sum_in     = '0;
            o_min_in     = '0;
            o_max_in     = '0;
            o_sq_in      = '0;
            last_in      = 1'b0;
            ret_in       = ST_PNEXT;
            state_in     = ST_OUT;
         end
         ST_PNEXT: begin
            if (p_ff == LAST_PCT) begin
               state_in = ST_RNEXT;
            end else begin
               p_in     = p_ff + 3'd1;
               state_in = ST_PCT;
            end
         end
         ST_RNEXT: begin
            x0_in     = centre_ff;
            c0_in     = c_ff;
            centre_in = centre_ff + 64'(len);
            if (BIN_CW'(i_ff) == nb - BIN_CW'(1)) begin
               state_in = ST_STAT;
            end else begin
               i_in     = i_ff + BIN_AW'(1);
               state_in = ST_RRD;
            end
         end
         ST_STAT: begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_STAT;
            index_in     = '0;
            x_in         = '0;
            y_in         = '0;
            o_count_in   = total_ff;
            o_sum_in     = sum_ff;
            o_min_in     = min_ff;
            o_max_in     = max_ff;
            o_sq_in      = sqsum_ff;
            last_in      = 1'b1;
            ret_in       = ST_IDLE;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ret_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         min_value_ff  <= '0;
         bin_length_ff <= 31'd65536;
         num_bins_ff   <= 6'd32;
         mode_ff       <= MODE_COUNT;
         total_ff      <= '0;
         sum_ff        <= '0;
         min_ff        <= 32'sh7FFFFFFF;
         max_ff        <= 32'sh80000000;
         sqsum_ff      <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sqsum_ff     <= sqsum_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            case (reg_index_type'(csr_chan.index))
               REG_MIN_VALUE:   min_value_ff  <= csr_chan.data;
               REG_BIN_LENGTH:  bin_length_ff <= csr_chan.data[30:0];
               REG_NUM_BINS:    num_bins_ff   <= csr_chan.data[5:0];
               REG_OUTPUT_MODE: mode_ff       <= mode_type'(csr_chan.data[1:0]);
               default: ;
            endcase
         end
      end
      sv_ff       <= sv_in;
      sq_ff       <= sq_in;
      bin_ff      <= bin_in;
      i_ff        <= i_in;
      p_ff        <= p_in;
      c_ff        <= c_in;
      c0_ff       <= c0_in;
      x0_ff       <= x0_in;
      centre_ff   <= centre_in;
      prod_ff     <= prod_in;
      rd_valid_ff <= valid_ff[rd_addr];
      kind_ff     <= kind_in;
      index_ff    <= index_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      o_count_ff  <= o_count_in;
      o_sum_ff    <= o_sum_in;
      o_min_ff    <= o_min_in;
      o_max_ff    <= o_max_in;
      o_sq_ff     <= o_sq_in;
      last_ff     <= last_in;
   end

   hpc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   hpc_bin_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (bin_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.index        = index_ff;
   assign rsp_chan.x_value      = x_ff;
   assign rsp_chan.y_value      = y_ff;
   assign rsp_chan.sample_count = o_count_ff;
   assign rsp_chan.sample_sum   = o_sum_ff;
   assign rsp_chan.sample_min   = o_min_ff;
   assign rsp_chan.sample_max   = o_max_ff;
   assign rsp_chan.square_sum   = o_sq_ff;
   assign rsp_chan.last         = last_ff;

endmodule

// ===== hw/rtl/hpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_checker
// Port-level checks on the collector's response stream and request ready.
// ----------------------------------------------------------------------------
module hpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_x_value,
   input logic        rsp_last
);
   import hpc_pkg::*;

   a_last_is_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_STAT)
      else $error("last item is not a statistics item");

   a_stat_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STAT |-> rsp_last)
      else $error("statistics item without last");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_value))
      else $error("stalled response changed");

endmodule

bind histogram_percentile_collector_top hpc_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_x_value      (rsp_chan.x_value),
   .rsp_last         (rsp_chan.last)
);
